// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the RTL of the coin change engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked at every edge outside reset.
`define MCC_ASSERT(label, clk_i, rst_ni, prop, msg) \
    label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define MCC_ASSERT_ALWAYS(label, clk_i, prop, msg) \
    label: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define MCC_ASSERT(label, clk_i, rst_ni, prop, msg)

`define MCC_ASSERT_ALWAYS(label, clk_i, prop, msg)

`endif

`endif

// ===== src/mcc_pkg.sv =====
// ----------------------------------------------------------------------------
// mcc_pkg
// Types and constants shared by the minimum coin change block.
// ----------------------------------------------------------------------------
`default_nettype none

package mcc_pkg;

    localparam int MCC_MAX_COINS  = 512;
    localparam int MCC_MAX_AMOUNT = 65535;

    localparam int VALUE_W = 16;
    localparam int ENTRY_W = VALUE_W + 1;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_SOLVE = 2'd2,
        OP_NOP   = 2'd3
    } mcc_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COIN,
        S_CHECK,
        S_MERGE,
        S_WRITE
    } mcc_state_t;

    typedef struct packed {
        logic               valid;
        mcc_op_t            op;
        logic [VALUE_W-1:0] value;
        logic               res_free;
    } mcc_cmd_t;

    typedef struct packed {
        logic               idle;
        logic               res_valid;
        logic [VALUE_W-1:0] count;
        logic               reach;
    } mcc_stat_t;

endpackage

`default_nettype wire

// ===== src/mcc_item_if.sv =====
// ----------------------------------------------------------------------------
// mcc_item_if
// Input channel: one command per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcc_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [15:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

`default_nettype wire

// ===== src/mcc_result_if.sv =====
// ----------------------------------------------------------------------------
// mcc_result_if
// Output channel: one solve answer per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcc_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] min_coins;
    logic        reachable;

    modport source (output valid, output min_coins, output reachable, input ready);
    modport sink   (input valid, input min_coins, input reachable, output ready);
endinterface

`default_nettype wire

// ===== src/mcc_ram.sv =====
// ----------------------------------------------------------------------------
// mcc_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [WIDTH-1:0]  wdata,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/mcc_engine.sv =====
// ----------------------------------------------------------------------------
// mcc_engine
// Coin store and table walk: keeps the coin set in one RAM and fills the
// minimum-coins table in a second RAM, one coin of one amount at a time.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mcc_engine
    import mcc_pkg::*;
#(
    parameter int MAX_COINS  = MCC_MAX_COINS,
    parameter int MAX_AMOUNT = MCC_MAX_AMOUNT
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire mcc_cmd_t  cmd,
    output mcc_stat_t      stat
);

    localparam int CW = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
    localparam int NW = $clog2(MAX_COINS + 1);
    localparam int AW = $clog2(MAX_AMOUNT + 1);

    mcc_state_t         state_reg, state_next;
    logic [NW-1:0]      coin_count_reg, coin_count_next;
    logic [NW-1:0]      coin_idx_reg, coin_idx_next;
    logic [AW-1:0]      amount_reg, amount_next;
    logic [AW-1:0]      target_reg, target_next;
    logic [ENTRY_W-1:0] best_reg, best_next;

    logic               coin_we;
    logic [CW-1:0]      coin_addr;
    logic [VALUE_W-1:0] coin_rdata;
    logic               best_we;
    logic [AW-1:0]      best_addr;
    logic [ENTRY_W-1:0] best_wdata;
    logic [ENTRY_W-1:0] best_rdata;
    logic [VALUE_W-1:0] cand;

    mcc_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_COINS)
    ) u_coin_ram (
        .clk   (clk),
        .we    (coin_we),
        .addr  (coin_addr),
        .wdata (cmd.value),
        .rdata (coin_rdata)
    );

    mcc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_AMOUNT + 1)
    ) u_best_ram (
        .clk   (clk),
        .we    (best_we),
        .addr  (best_addr),
        .wdata (best_wdata),
        .rdata (best_rdata)
    );

    assign cand = best_rdata[VALUE_W-1:0] + VALUE_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            coin_count_reg <= '0;
            coin_idx_reg   <= '0;
            amount_reg     <= '0;
            target_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            coin_count_reg <= coin_count_next;
            coin_idx_reg   <= coin_idx_next;
            amount_reg     <= amount_next;
            target_reg     <= target_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        coin_count_next = coin_count_reg;
        coin_idx_next   = coin_idx_reg;
        amount_next     = amount_reg;
        target_next     = target_reg;
        best_next       = best_reg;
        coin_we         = 1'b0;
        coin_addr       = coin_count_reg[CW-1:0];
        best_we         = 1'b0;
        best_addr       = amount_reg;
        best_wdata      = best_reg;
        stat            = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                stat.idle = 1'b1;
                if (cmd.valid)
                begin
                    unique case (cmd.op)
                        OP_CLEAR:
                        begin
                            coin_count_next = '0;
                        end
                        OP_ADD:
                        begin
                            if (cmd.value != '0 && coin_count_reg < NW'(MAX_COINS))
                            begin
                                coin_we         = 1'b1;
                                coin_count_next = coin_count_reg + NW'(1);
                            end
                        end
                        OP_SOLVE:
                        begin
                            if (32'(cmd.value) > 32'(MAX_AMOUNT))
                            begin
                                stat.res_valid = 1'b1;
                            end
                            else if (cmd.value == '0)
                            begin
                                stat.res_valid = 1'b1;
                                stat.reach     = 1'b1;
                            end
                            else
                            begin
                                best_we       = 1'b1;
                                best_addr     = '0;
                                best_wdata    = {1'b1, {VALUE_W{1'b0}}};
                                target_next   = AW'(cmd.value);
                                amount_next   = AW'(1);
                                coin_idx_next = '0;
                                best_next     = '0;
                                state_next    = S_COIN;
                            end
                        end
                        OP_NOP:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_COIN:
            begin
                if (coin_idx_reg == coin_count_reg)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    coin_addr  = coin_idx_reg[CW-1:0];
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (coin_rdata != '0 && 32'(coin_rdata) <= 32'(amount_reg))
                begin
                    best_addr  = amount_reg - AW'(coin_rdata);
                    state_next = S_MERGE;
                end
                else
                begin
                    coin_idx_next = coin_idx_reg + NW'(1);
                    state_next    = S_COIN;
                end
            end
            S_MERGE:
            begin
                if (best_rdata[VALUE_W] &&
                    (!best_reg[VALUE_W] || cand < best_reg[VALUE_W-1:0]))
                begin
                    best_next = {1'b1, cand};
                end
                coin_idx_next = coin_idx_reg + NW'(1);
                state_next    = S_COIN;
            end
            S_WRITE:
            begin
                if (amount_reg == target_reg)
                begin
                    if (cmd.res_free)
                    begin
                        best_we        = 1'b1;
                        stat.res_valid = 1'b1;
                        stat.reach     = best_reg[VALUE_W];
                        stat.count     = best_reg[VALUE_W] ? best_reg[VALUE_W-1:0] : '0;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    best_we       = 1'b1;
                    amount_next   = amount_reg + AW'(1);
                    coin_idx_next = '0;
                    best_next     = '0;
                    state_next    = S_COIN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `MCC_ASSERT(a_count_bound, clk, rst_n, coin_count_reg <= NW'(MAX_COINS), "coin count above capacity")
    `MCC_ASSERT(a_read_below, clk, rst_n, (state_reg == S_CHECK && state_next == S_MERGE) |-> (best_addr < amount_reg), "table read not below current amount")
    `MCC_ASSERT(a_amount_range, clk, rst_n, (state_reg != S_IDLE) |-> (amount_reg != '0 && amount_reg <= target_reg), "amount walk out of range")
    `MCC_ASSERT(a_idx_bound, clk, rst_n, (state_reg != S_IDLE) |-> (coin_idx_reg <= coin_count_reg), "coin index past coin count")
    `MCC_ASSERT(a_res_slot, clk, rst_n, stat.res_valid |-> cmd.res_free, "result issued while output slot busy")

endmodule

`default_nettype wire

// ===== src/min_coin_change.sv =====
// ----------------------------------------------------------------------------
// min_coin_change
// Unbounded coin change: fewest coins that sum to a requested amount.
// ----------------------------------------------------------------------------
// Clear and add commands can stream back to back; an add of a zero coin or
// an add to a full coin set is dropped. A solve for amount A with N stored
// coins builds the table from 0 to A and holds the input until it is done:
// every coin of every amount takes a read on the port of the coin RAM, a
// check and, when the coin fits, a read on the port of the table RAM, and
// every amount ends with a step to close the coin walk and one to write its
// entry. A coin larger than the amount skips the table read. Amount 0 and
// amounts above MAX_AMOUNT are answered in the cycle after they are
// accepted. The answer sits in an output register; while it waits for its
// transfer no new command is taken, and a finished solve holds its last step
// until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module min_coin_change
    import mcc_pkg::*;
#(
    parameter int MAX_COINS  = MCC_MAX_COINS,
    parameter int MAX_AMOUNT = MCC_MAX_AMOUNT
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    mcc_item_if.sink      items,
    mcc_result_if.source  results
);

    mcc_cmd_t           cmd;
    mcc_stat_t          stat;
    logic               res_free;
    logic               out_valid_reg;
    logic [VALUE_W-1:0] min_coins_reg;
    logic               reachable_reg;

    assign res_free    = !out_valid_reg || results.ready;
    assign items.ready = stat.idle && res_free;

    assign cmd.valid    = items.valid && items.ready;
    assign cmd.op       = mcc_op_t'(items.opcode);
    assign cmd.value    = items.value;
    assign cmd.res_free = res_free;

    mcc_engine #(
        .MAX_COINS  (MAX_COINS),
        .MAX_AMOUNT (MAX_AMOUNT)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stat.res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.res_valid)
        begin
            min_coins_reg <= stat.count;
            reachable_reg <= stat.reach;
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.min_coins = min_coins_reg;
    assign results.reachable = reachable_reg;

endmodule

`default_nettype wire
